@@ rtl/tsip_pkg.sv @@
// ----------------------------------------------------------------------------
// tsip_pkg
// Shared types and constants for the Thumb system-instruction patcher.
// ----------------------------------------------------------------------------
package tsip_pkg;

   // fixed encodings
   localparam logic [15:0] SVC_SYS   = 16'hdffe;
   localparam logic [15:0] SVC_WFI   = 16'hdffd;
   localparam logic [15:0] NOP_HW    = 16'hbf00;
   localparam logic [15:0] WFI_HW    = 16'hbf30;
   localparam logic [15:0] MSR1_MASK = 16'hfff0;
   localparam logic [15:0] MSR1_VAL  = 16'hf380;
   localparam logic [15:0] MSR2_MASK = 16'hf300;
   localparam logic [15:0] MRS2_MASK = 16'hf000;
   localparam logic [15:0] SYS2_VAL  = 16'h8000;
   localparam logic [15:0] CPS_VAL   = 16'hb660;

   // register reset values
   localparam logic [31:0] BASE_ADDR_RST  = 32'h0000_0000;
   localparam logic [15:0] MRS_FIRST_RST  = 16'hf3ef;
   localparam logic [15:0] CPS_MASK_RST   = 16'hffec;
   localparam logic [15:0] BREAK_WORD_RST = 16'hbf01;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int INDEX_W     = 31;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDR    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MRS_FIRST    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CPS_MASK     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROFILE_MODE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BREAK_WORD   = 3'd4;

   // match kinds
   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_MSR  = 3'd1;
   localparam logic [2:0] KIND_MRS  = 3'd2;
   localparam logic [2:0] KIND_CPS  = 3'd3;
   localparam logic [2:0] KIND_WFI  = 3'd4;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [31:0] base_addr;
      logic [15:0] mrs_first_value;
      logic [15:0] cps_match_mask;
      logic        profile_mode;
      logic [15:0] break_word;
   } tsip_cfg_type;

   typedef struct packed {
      logic [15:0] patched_word;
      logic [31:0] word_address;
      logic [2:0]  match_kind;
      logic [3:0]  core_reg;
      logic [7:0]  sys_reg;
      logic [1:0]  write_mask;
      logic        cps_im;
      logic        cps_i;
      logic        cps_f;
      logic        run_end;
   } tsip_rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic can_take_two;
   } tsip_qstat_type;

endpackage

@@ rtl/tsip_decode.sv @@
// ----------------------------------------------------------------------------
// tsip_decode
// Matches and rewrites one halfword using its look-ahead halfword.
// ----------------------------------------------------------------------------
module tsip_decode (
   input  logic [15:0]           word,
   input  logic [15:0]           next_word,
   input  logic                  in_block,
   input  logic [31:0]           word_address,
   input  logic                  last_word,
   input  tsip_pkg::tsip_cfg_type cfg,
   output tsip_pkg::tsip_rsp_type rsp,
   output logic [15:0]           next_out
);
   import tsip_pkg::*;

   logic [15:0] rep;
   logic [15:0] w;
   logic [15:0] n;

   assign rep = cfg.profile_mode ? cfg.break_word : SVC_SYS;

   // checks run in order, each on the already rewritten halfword
   always_comb begin
      w   = word;
      n   = next_word;
      rsp = '0;
      if (in_block) begin
         if ((w & MSR1_MASK) == MSR1_VAL && (n & MSR2_MASK) == SYS2_VAL) begin
            rsp.match_kind = KIND_MSR;
            rsp.core_reg   = w[3:0];
            rsp.write_mask = n[11:10];
            rsp.sys_reg    = n[7:0];
            w = rep;
            n = NOP_HW;
         end
         if (w == cfg.mrs_first_value && (n & MRS2_MASK) == SYS2_VAL) begin
            rsp.match_kind = KIND_MRS;
            rsp.core_reg   = n[11:8];
            rsp.sys_reg    = n[7:0];
            rsp.write_mask = 2'd0;
            w = rep;
            n = NOP_HW;
         end
         if ((w & cfg.cps_match_mask) == CPS_VAL) begin
            rsp.match_kind = KIND_CPS;
            rsp.core_reg   = 4'd0;
            rsp.sys_reg    = 8'd0;
            rsp.write_mask = 2'd0;
            rsp.cps_im     = w[4];
            rsp.cps_i      = w[1];
            rsp.cps_f      = w[0];
            w = rep;
         end
         if (w == WFI_HW) begin
            if (rsp.match_kind == KIND_NONE) begin
               rsp.match_kind = KIND_WFI;
            end
            if (!cfg.profile_mode) begin
               w = SVC_WFI;
            end
         end
      end
      rsp.patched_word = w;
      rsp.word_address = word_address;
      rsp.run_end      = last_word;
      next_out         = n;
   end

endmodule

@@ rtl/tsip_result_queue.sv @@
// ----------------------------------------------------------------------------
// tsip_result_queue
// Four-entry result queue; takes up to two results per cycle, emits one.
// ----------------------------------------------------------------------------
module tsip_result_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             push_count,
   input  tsip_pkg::tsip_rsp_type push_data0,
   input  tsip_pkg::tsip_rsp_type push_data1,
   output tsip_pkg::tsip_rsp_type head,
   output logic                   head_valid,
   input  logic                   pop,
   output tsip_pkg::tsip_qstat_type status
);
   import tsip_pkg::*;

   tsip_rsp_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     wr_ptr_1;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  do_pop;

   function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
      ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;
   assign wr_ptr_1   = ptr_inc(wr_ptr_ff);

   assign status.full         = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty        = !head_valid;
   assign status.can_take_two = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));

   always_comb begin
      rd_ptr_in = do_pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      case (push_count)
         2'd1:    wr_ptr_in = wr_ptr_1;
         2'd2:    wr_ptr_in = ptr_inc(wr_ptr_1);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + QCNT_W'(push_count) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_data0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_1] <= push_data1;
      end
   end

endmodule

@@ rtl/thumb_system_insn_patcher_top.sv @@
// ----------------------------------------------------------------------------
// thumb_system_insn_patcher_top
// Rewrites MSR/MRS/CPS (and WFI) in a Thumb halfword stream, one halfword
// held back as look-ahead.
//
//   channel | direction | handshake           | carries
//   req     | in        | req_valid/req_ready | halfword, in_block, final_item
//   rsp     | out       | rsp_valid/rsp_ready | patched halfword + decode info
//   csr     | in        | csr_write_en        | register index + write data
//
// One halfword per cycle: decode is a single pass from the held register into
// a 4-entry result queue. A final halfword with a held word yields two
// results; the queue takes both at once and req_ready drops while it holds
// more than two. Reset is synchronous; it clears the held word, the index,
// the queue and loads register defaults. rsp stalls back up only via the queue.
// ----------------------------------------------------------------------------
module thumb_system_insn_patcher_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [15:0]                      req_halfword,
   input  logic                             req_in_block,
   input  logic                             req_final_item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [15:0]                      rsp_patched_word,
   output logic [31:0]                      rsp_word_address,
   output logic [2:0]                       rsp_match_kind,
   output logic [3:0]                       rsp_core_reg,
   output logic [7:0]                       rsp_sys_reg,
   output logic [1:0]                       rsp_write_mask,
   output logic                             rsp_cps_im,
   output logic                             rsp_cps_i,
   output logic                             rsp_cps_f,
   output logic                             rsp_run_end,
   input  logic                             csr_write_en,
   input  logic [tsip_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tsip_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tsip_pkg::*;

   tsip_cfg_type        cfg_ff;
   logic [15:0]         held_word_ff, held_word_in;
   logic                held_valid_ff, held_valid_in;
   logic                held_in_block_ff, held_in_block_in;
   logic [INDEX_W-1:0]  word_index_ff, word_index_in;
   logic [INDEX_W-1:0]  index_b;
   logic [31:0]         addr_a, addr_b;
   logic [15:0]         next_a, next_b, word_b;
   tsip_rsp_type        rsp_a, rsp_b, push0, push1, head;
   logic [1:0]          push_count;
   logic                req_fire;
   tsip_qstat_type      qstat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_addr       <= BASE_ADDR_RST;
         cfg_ff.mrs_first_value <= MRS_FIRST_RST;
         cfg_ff.cps_match_mask  <= CPS_MASK_RST;
         cfg_ff.profile_mode    <= 1'b0;
         cfg_ff.break_word      <= BREAK_WORD_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BASE_ADDR:    cfg_ff.base_addr       <= csr_wdata;
            CSR_MRS_FIRST:    cfg_ff.mrs_first_value <= csr_wdata[15:0];
            CSR_CPS_MASK:     cfg_ff.cps_match_mask  <= csr_wdata[15:0];
            CSR_PROFILE_MODE: cfg_ff.profile_mode    <= csr_wdata[0];
            CSR_BREAK_WORD:   cfg_ff.break_word      <= csr_wdata[15:0];
            default:          ;
         endcase
      end
   end

   assign req_ready = qstat.can_take_two;
   assign req_fire  = req_valid && req_ready;

   assign index_b = held_valid_ff ? word_index_ff + INDEX_W'(1) : word_index_ff;
   assign addr_a  = cfg_ff.base_addr + {word_index_ff, 1'b0};
   assign addr_b  = cfg_ff.base_addr + {index_b, 1'b0};

   // held word, with the incoming halfword as look-ahead
   tsip_decode u_decode_held (
      .word         (held_word_ff),
      .next_word    (req_halfword),
      .in_block     (held_in_block_ff),
      .word_address (addr_a),
      .last_word    (1'b0),
      .cfg          (cfg_ff),
      .rsp          (rsp_a),
      .next_out     (next_a)
   );

   // incoming halfword on a final transaction, zero look-ahead
   assign word_b = held_valid_ff ? next_a : req_halfword;

   tsip_decode u_decode_final (
      .word         (word_b),
      .next_word    (16'h0000),
      .in_block     (req_in_block),
      .word_address (addr_b),
      .last_word    (1'b1),
      .cfg          (cfg_ff),
      .rsp          (rsp_b),
      .next_out     (next_b)
   );

   always_comb begin
      held_word_in     = held_word_ff;
      held_valid_in    = held_valid_ff;
      held_in_block_in = held_in_block_ff;
      word_index_in    = word_index_ff;
      push_count       = 2'd0;
      push0            = rsp_a;
      push1            = rsp_b;
      if (req_fire) begin
         if (req_final_item) begin
            held_word_in     = next_b;
            held_valid_in    = 1'b0;
            held_in_block_in = 1'b0;
            word_index_in    = '0;
            if (held_valid_ff) begin
               push_count = 2'd2;
            end else begin
               push_count = 2'd1;
               push0      = rsp_b;
            end
         end else begin
            held_word_in     = word_b;
            held_valid_in    = 1'b1;
            held_in_block_in = req_in_block;
            word_index_in    = index_b;
            push_count       = held_valid_ff ? 2'd1 : 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_word_ff     <= '0;
         held_valid_ff    <= 1'b0;
         held_in_block_ff <= 1'b0;
         word_index_ff    <= '0;
      end else begin
         held_word_ff     <= held_word_in;
         held_valid_ff    <= held_valid_in;
         held_in_block_ff <= held_in_block_in;
         word_index_ff    <= word_index_in;
      end
   end

   tsip_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data0 (push0),
      .push_data1 (push1),
      .head       (head),
      .head_valid (rsp_valid),
      .pop        (rsp_ready),
      .status     (qstat)
   );

   assign rsp_patched_word = head.patched_word;
   assign rsp_word_address = head.word_address;
   assign rsp_match_kind   = head.match_kind;
   assign rsp_core_reg     = head.core_reg;
   assign rsp_sys_reg      = head.sys_reg;
   assign rsp_write_mask   = head.write_mask;
   assign rsp_cps_im       = head.cps_im;
   assign rsp_cps_i        = head.cps_i;
   assign rsp_cps_f        = head.cps_f;
   assign rsp_run_end      = head.run_end;

   // a final transaction restarts the stream
   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_final_item |=> !held_valid_ff && word_index_ff == '0)
      else $error("stream not restarted after final halfword");

   // a non-final transaction always leaves a held word
   a_hold_after_word: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_final_item |=> held_valid_ff)
      else $error("halfword not held");

   // results queue has room whenever a transaction is taken
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !qstat.full)
      else $error("result queue overflow");

   // two results only come from a final transaction with a held word
   a_two_results: assert property (@(posedge clock) disable iff (reset)
      push_count == 2'd2 |-> req_final_item && held_valid_ff)
      else $error("unexpected double result");

endmodule

@@ tb/patch_check_pkg.sv @@
// ----------------------------------------------------------------------------
// patch_check_pkg
// Prediction and checking for the Thumb system-instruction patcher: tracks
// the held halfword, register settings and the queue of predicted results.
// ----------------------------------------------------------------------------
package patch_check_pkg;

   import tsip_pkg::*;

   class patch_tracker;

      tsip_cfg_type     cfg;
      logic [15:0]      held_word;
      bit               held_valid;
      bit               held_in_block;
      logic [30:0]      word_index;
      tsip_rsp_type     pending_words[$];
      int               errors;

      function new();
         cfg.base_addr       = BASE_ADDR_RST;
         cfg.mrs_first_value = MRS_FIRST_RST;
         cfg.cps_match_mask  = CPS_MASK_RST;
         cfg.profile_mode    = 1'b0;
         cfg.break_word      = BREAK_WORD_RST;
         held_word           = '0;
         held_valid          = 1'b0;
         held_in_block       = 1'b0;
         word_index          = '0;
         errors              = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_BASE_ADDR:    cfg.base_addr       = val;
            CSR_MRS_FIRST:    cfg.mrs_first_value = val[15:0];
            CSR_CPS_MASK:     cfg.cps_match_mask  = val[15:0];
            CSR_PROFILE_MODE: cfg.profile_mode    = val[0];
            CSR_BREAK_WORD:   cfg.break_word      = val[15:0];
            default: ;
         endcase
      endfunction

      // Decode and rewrite one halfword; the look-ahead may be replaced by NOP.
      function tsip_rsp_type rewrite_halfword(logic [15:0] w, inout logic [15:0] nxt,
                                              input bit inb, input logic [30:0] idx);
         tsip_rsp_type r;
         logic [15:0]  rep;
         r   = '0;
         rep = cfg.profile_mode ? cfg.break_word : SVC_SYS;
         if (inb) begin
            if ((w & MSR1_MASK) == MSR1_VAL && (nxt & MSR2_MASK) == SYS2_VAL) begin
               r.match_kind = KIND_MSR;
               r.core_reg   = w[3:0];
               r.write_mask = nxt[11:10];
               r.sys_reg    = nxt[7:0];
               w            = rep;
               nxt          = NOP_HW;
            end
            if (w == cfg.mrs_first_value && (nxt & MRS2_MASK) == SYS2_VAL) begin
               r.match_kind = KIND_MRS;
               r.core_reg   = nxt[11:8];
               r.sys_reg    = nxt[7:0];
               r.write_mask = '0;
               w            = rep;
               nxt          = NOP_HW;
            end
            if ((w & cfg.cps_match_mask) == CPS_VAL) begin
               r.match_kind = KIND_CPS;
               r.core_reg   = '0;
               r.sys_reg    = '0;
               r.write_mask = '0;
               r.cps_im     = w[4];
               r.cps_i      = w[1];
               r.cps_f      = w[0];
               w            = rep;
            end
            // WFI only reports when nothing else hit this halfword
            if (w == WFI_HW) begin
               if (r.match_kind == KIND_NONE) r.match_kind = KIND_WFI;
               if (!cfg.profile_mode) w = SVC_WFI;
            end
         end
         r.patched_word = w;
         r.word_address = cfg.base_addr + {idx, 1'b0};
         return r;
      endfunction

      function void note_halfword(logic [15:0] hw, bit inb, bit fin);
         tsip_rsp_type r;
         logic [15:0]  nxt;
         logic [15:0]  no_next;
         nxt = hw;
         if (held_valid) begin
            r = rewrite_halfword(held_word, nxt, held_in_block, word_index);
            pending_words = {pending_words, r};
            word_index++;
         end
         if (fin) begin
            no_next   = '0;
            r         = rewrite_halfword(nxt, no_next, inb, word_index);
            r.run_end = 1'b1;
            pending_words = {pending_words, r};
            held_valid    = 1'b0;
            held_in_block = 1'b0;
            held_word     = '0;
            word_index    = '0;
         end else begin
            held_word     = nxt;
            held_in_block = inb;
            held_valid    = 1'b1;
         end
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_word(tsip_rsp_type got);
         tsip_rsp_type want;
         if (pending_words.size() == 0) begin
            $error("result transaction with none pending: word 0x%0h at 0x%0h",
                   got.patched_word, got.word_address);
            errors++;
            return;
         end
         want = pending_words.pop_front();
         compare_field("patched_word", want.patched_word, got.patched_word);
         compare_field("word_address", want.word_address, got.word_address);
         compare_field("match_kind",   want.match_kind,   got.match_kind);
         compare_field("core_reg",     want.core_reg,     got.core_reg);
         compare_field("sys_reg",      want.sys_reg,      got.sys_reg);
         compare_field("write_mask",   want.write_mask,   got.write_mask);
         compare_field("cps_im",       want.cps_im,       got.cps_im);
         compare_field("cps_i",        want.cps_i,        got.cps_i);
         compare_field("cps_f",        want.cps_f,        got.cps_f);
         compare_field("run_end",      want.run_end,      got.run_end);
      endfunction

   endclass

endpackage

@@ tb/tb_thumb_system_insn_patcher_top.sv @@
// ----------------------------------------------------------------------------
// tb_thumb_system_insn_patcher_top
// Streams firmware images through the patcher under several register
// settings, with random stalls on both channels, and checks every result
// transaction against a cycle-free prediction of the rewrite.
// ----------------------------------------------------------------------------
module tb_thumb_system_insn_patcher_top;

   timeunit 1ns;
   timeprecision 1ps;

   import tsip_pkg::*;
   import patch_check_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 11;
   localparam int IDLE_PCT        = 28;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 216;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_CYCLES     = 150;
   localparam int WATCHDOG_LIMIT  = 2000;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = CSR_BREAK_WORD + 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = '1;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic [15:0]            req_halfword   = '0;
   logic                   req_in_block   = 1'b0;
   logic                   req_final_item = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic [15:0]            rsp_patched_word;
   logic [31:0]            rsp_word_address;
   logic [2:0]             rsp_match_kind;
   logic [3:0]             rsp_core_reg;
   logic [7:0]             rsp_sys_reg;
   logic [1:0]             rsp_write_mask;
   logic                   rsp_cps_im;
   logic                   rsp_cps_i;
   logic                   rsp_cps_f;
   logic                   rsp_run_end;
   logic                   csr_write_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata      = '0;

   patch_tracker tracker;
   bit           sender_calm   = 1'b0;
   bit           receiver_calm = 1'b0;
   int           holdoff_req   = 0;
   int           holdoff_seen  = 0;
   int           hold_left     = 0;
   int           idle_cycles   = 0;

   thumb_system_insn_patcher_top u_top (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   // result side: check, then pick next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            tracker.check_word({rsp_patched_word, rsp_word_address, rsp_match_kind,
                                rsp_core_reg, rsp_sys_reg, rsp_write_mask, rsp_cps_im,
                                rsp_cps_i, rsp_cps_f, rsp_run_end});
         if (holdoff_req != holdoff_seen) begin
            holdoff_seen = holdoff_req;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= receiver_calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_halfword(logic [15:0] hw, bit inb, bit fin);
      while (!sender_calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_halfword   <= hw;
      req_in_block   <= inb;
      req_final_item <= fin;
      do @(posedge clock); while (!req_ready);
      tracker.note_halfword(hw, inb, fin);
   endtask

   // one image: mostly well-formed patterns, some broken pairs and noise
   task automatic send_image(int len);
      logic [15:0]  words[$];
      logic [15:0]  r;
      int           pick;
      tsip_cfg_type c;
      c = tracker.cfg;
      while (words.size() < len) begin
         r    = 16'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 18) begin
            words = {words, MSR1_VAL | {12'h000, r[3:0]}};
            words = {words, SYS2_VAL | (16'($urandom) & ~MSR2_MASK)};
         end else if (pick < 34) begin
            words = {words, c.mrs_first_value};
            words = {words, SYS2_VAL | (16'($urandom) & ~MRS2_MASK)};
         end else if (pick < 50) begin
            words = {words, CPS_VAL | (r & ~c.cps_match_mask)};
         end else if (pick < 58) begin
            words = {words, WFI_HW};
         end else if (pick < 68) begin
            words = {words, r[0] ? (MSR1_VAL | {12'h000, r[7:4]}) : c.mrs_first_value};
            words = {words, 16'($urandom)};
         end else begin
            words = {words, r};
         end
      end
      for (int i = 0; i < len; i++)
         push_halfword(words[i], $urandom_range(0, 99) < 88, i == len - 1);
   endtask

   task automatic run_phase(int items);
      int left;
      int len;
      left = items;
      while (left > 0) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
         if (len > left) len = left;
         send_image(len);
         left -= len;
      end
      req_valid <= 1'b0;
   endtask

   // wait for every predicted result, then let the pipeline go quiet
   task automatic settle();
      while (tracker.pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_registers(logic [31:0] base, logic [15:0] mrs, logic [15:0] mask,
                                    logic [15:0] brk, bit prof);
      logic [CSR_INDEX_W-1:0] idx[6];
      logic [CSR_DATA_W-1:0]  dat[6];
      logic [31:0]            r;
      r = $urandom;
      idx[0] = CSR_BASE_ADDR;    dat[0] = base;
      idx[1] = CSR_MRS_FIRST;    dat[1] = {r[31:16], mrs};
      idx[2] = CSR_CPS_MASK;     dat[2] = {r[15:0], mask};
      idx[3] = CSR_PROFILE_MODE; dat[3] = {r[30:0], prof};
      idx[4] = CSR_BREAK_WORD;   dat[4] = {r[23:8], brk};
      // unused index last, so an aliased decode would clobber a live register
      idx[5] = CSR_INDEX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST));
      dat[5] = $urandom;
      for (int i = 0; i < 6; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= idx[i];
         csr_wdata    <= dat[i];
         @(posedge clock);
         tracker.set_register(idx[i], dat[i]);
      end
      csr_write_en <= 1'b0;
   endtask

   task automatic configure_phase(int p);
      logic [31:0] base;
      logic [15:0] mrs;
      logic [15:0] mask;
      logic [15:0] brk;
      bit          prof;
      base = BASE_ADDR_RST;
      mrs  = MRS_FIRST_RST;
      mask = CPS_MASK_RST;
      brk  = BREAK_WORD_RST;
      prof = 1'b0;
      case (p)
         0: base = 32'hffff_fff0;
         1: begin
            prof = 1'b1; brk = WFI_HW; base = '1;
         end
         2: begin
            prof = 1'b1; brk = CPS_VAL; mrs = NOP_HW; mask = 16'hffff; base = $urandom;
         end
         3: begin
            mrs = NOP_HW; mask = 16'h0000;
         end
         4: begin
            prof = 1'b1; brk = 16'h0000; mrs = 16'hffff; base = $urandom;
         end
         5: begin
            prof = 1'b1; brk = 16'hffff; mrs = 16'h0000; mask = CPS_VAL;
         end
         default: begin
            base = $urandom;
            prof = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
               0: mrs = MRS_FIRST_RST;
               1: mrs = NOP_HW;
               2: mrs = MSR1_VAL | 16'($urandom_range(0, 15));
               default: mrs = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
               0: mask = CPS_MASK_RST;
               1: mask = 16'hffff;
               2: mask = 16'h0000;
               default: mask = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
               0: brk = BREAK_WORD_RST;
               1: brk = WFI_HW;
               2: brk = CPS_VAL;
               default: brk = 16'($urandom);
            endcase
         end
      endcase
      program_registers(base, mrs, mask, brk, prof);
   endtask

   // reset register values
   task automatic run_directed();
      push_halfword(16'h0000, 1'b0, 1'b1);                  // lone final halfword
      push_halfword(16'hffff, 1'b1, 1'b0);
      push_halfword(MSR1_VAL | 16'h0005, 1'b1, 1'b0);       // MSR r5, mask 3, SYSm 0xff
      push_halfword(16'h8cff, 1'b1, 1'b0);
      push_halfword(MRS_FIRST_RST, 1'b1, 1'b0);             // MRS r15
      push_halfword(16'h8f14, 1'b1, 1'b0);
      push_halfword(16'hb672, 1'b1, 1'b0);                  // CPSID i
      push_halfword(16'hb663, 1'b1, 1'b0);
      push_halfword(WFI_HW, 1'b1, 1'b0);
      push_halfword(MSR1_VAL, 1'b0, 1'b0);                  // outside any block
      push_halfword(16'h8800, 1'b0, 1'b0);
      push_halfword(WFI_HW, 1'b0, 1'b0);
      push_halfword(MSR1_VAL | 16'h0001, 1'b1, 1'b0);       // bad second halfwords, then a valid MSR r15
      push_halfword(16'h9000, 1'b1, 1'b0);
      push_halfword(MRS_FIRST_RST, 1'b1, 1'b0);
      push_halfword(16'h7f00, 1'b1, 1'b0);
      push_halfword(MSR1_VAL | 16'h000f, 1'b1, 1'b0);
      push_halfword(16'h8800, 1'b1, 1'b0);
      push_halfword(MSR1_VAL, 1'b1, 1'b1);                  // final sees zero look-ahead
      push_halfword(WFI_HW, 1'b1, 1'b1);
      push_halfword(MRS_FIRST_RST, 1'b1, 1'b0);             // pair whose second is final
      push_halfword(16'h8000, 1'b1, 1'b1);
      req_valid <= 1'b0;
   endtask

   initial begin
      tracker = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         configure_phase(p);
         sender_calm   = (p == 3);
         receiver_calm = (p == 3);
         // long receiver stall while items keep coming
         if (p == 3 || p == 6) holdoff_req++;
         run_phase(ITEMS_PER_PHASE);
      end
      settle();
      if (tracker.errors == 0 && tracker.pending_words.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
